/* src/sts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and token codes for the source token scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int POSITION_BITS  = 32;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    // token kinds
    localparam logic [4:0] KIND_INT     = 5'd0;
    localparam logic [4:0] KIND_NAME    = 5'd1;
    localparam logic [4:0] KIND_DO      = 5'd2;
    localparam logic [4:0] KIND_IF      = 5'd3;
    localparam logic [4:0] KIND_ELSE    = 5'd4;
    localparam logic [4:0] KIND_WHILE   = 5'd5;
    localparam logic [4:0] KIND_END     = 5'd6;
    localparam logic [4:0] KIND_STRING  = 5'd7;
    localparam logic [4:0] KIND_LPAREN  = 5'd8;
    localparam logic [4:0] KIND_RPAREN  = 5'd9;
    localparam logic [4:0] KIND_LBRACK  = 5'd10;
    localparam logic [4:0] KIND_RBRACK  = 5'd11;
    localparam logic [4:0] KIND_LBRACE  = 5'd12;
    localparam logic [4:0] KIND_RBRACE  = 5'd13;
    localparam logic [4:0] KIND_COMMA   = 5'd14;
    localparam logic [4:0] KIND_OPER    = 5'd15;
    localparam logic [4:0] KIND_UNKNOWN = 5'd16;
    localparam logic [4:0] KIND_EOF     = 5'd17;

    // operator codes
    localparam logic [3:0] OPC_ASSIGN = 4'd0;
    localparam logic [3:0] OPC_EQ     = 4'd1;
    localparam logic [3:0] OPC_GT     = 4'd2;
    localparam logic [3:0] OPC_GE     = 4'd3;
    localparam logic [3:0] OPC_LT     = 4'd4;
    localparam logic [3:0] OPC_LE     = 4'd5;
    localparam logic [3:0] OPC_NE     = 4'd6;
    localparam logic [3:0] OPC_ADD    = 4'd7;
    localparam logic [3:0] OPC_SUB    = 4'd8;
    localparam logic [3:0] OPC_MUL    = 4'd9;
    localparam logic [3:0] OPC_MOD    = 4'd10;
    localparam logic [3:0] OPC_DOT    = 4'd11;
    localparam logic [3:0] OPC_DIV    = 4'd12;

    // binding strengths
    localparam logic [4:0] PREC_NONE    = 5'd0;
    localparam logic [4:0] PREC_ASSIGN  = 5'd5;
    localparam logic [4:0] PREC_ADD     = 5'd10;
    localparam logic [4:0] PREC_MUL     = 5'd15;
    localparam logic [4:0] PREC_COMPARE = 5'd20;
    localparam logic [4:0] PREC_DOT     = 5'd25;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_INT,
        MODE_NAME,
        MODE_STR,
        MODE_CMT,
        MODE_OPW
    } scan_mode_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [3:0]  opc;
        logic [4:0]  prec;
        logic [31:0] start;
        logic [31:0] len;
        logic [7:0]  uch;
        logic        last;
    } token_t;

    // tokens caused by one input beat; tok1 is present only when two is set
    typedef struct packed {
        logic   two;
        token_t tok1;
        token_t tok0;
    } bundle_t;

endpackage

/* src/source_token_scanner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_token_scanner
// Streaming lexer: source bytes in, tokens with kind, operator code,
// precedence, start offset and length out.
// ----------------------------------------------------------------------------
// Feed the source one byte per beat (op low), then one end-of-input beat
// (op high), which flushes any open token, emits an eof token and returns the
// scanner to its reset state. A byte beat is taken every cycle while the
// four-entry token queue has room; a beat yields zero, one or two tokens, and
// the output port delivers one token per cycle while out_stall is low, so the
// sustained rate is one byte per cycle except where a byte both closes a token
// and forms one of its own, giving two tokens. Each token is queued and then
// registered at the output. last_of_run marks the final token of each beat.
// ----------------------------------------------------------------------------
module source_token_scanner
    import sts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  char_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  token_kind,
    output logic [3:0]  operator_code,
    output logic [4:0]  precedence,
    output logic [31:0] token_start,
    output logic [31:0] token_length,
    output logic [7:0]  unknown_char,
    output logic        last_of_run
);

    logic    push;
    bundle_t push_data;
    logic    queue_full;
    logic    queue_empty;
    logic    pop;
    bundle_t head;

    sts_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .char_in    (char_in),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    sts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .head      (head),
        .empty     (queue_empty)
    );

    sts_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .queue_empty   (queue_empty),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .token_kind    (token_kind),
        .operator_code (operator_code),
        .precedence    (precedence),
        .token_start   (token_start),
        .token_length  (token_length),
        .unknown_char  (unknown_char),
        .last_of_run   (last_of_run)
    );

endmodule

/* src/sts_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_front
// Scanner front end: accepts source bytes, tracks the open token and hands
// the one or two tokens that each byte completes to the token queue.
// ----------------------------------------------------------------------------
module sts_front
    import sts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  char_in,
    input  logic        queue_full,
    output logic        push,
    output bundle_t     push_data
);

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [39:0] KW_DO    = 40'h00_0000_646F;
    localparam logic [39:0] KW_IF    = 40'h00_0000_6966;
    localparam logic [39:0] KW_ELSE  = 40'h00_656C_7365;
    localparam logic [39:0] KW_WHILE = 40'h77_6869_6C65;
    localparam logic [39:0] KW_END   = 40'h00_0065_6E64;

    localparam logic [31:0] LEN_ONE  = 32'd1;
    localparam logic [31:0] LEN_TWO  = 32'd2;
    localparam logic [31:0] LEN_NONE = 32'd0;
    localparam logic [31:0] LEN_KW2  = 32'd2;
    localparam logic [31:0] LEN_KW3  = 32'd3;
    localparam logic [31:0] LEN_KW4  = 32'd4;
    localparam logic [31:0] LEN_KW5  = 32'd5;

    function automatic token_t make_tok(
        input logic [4:0]  kind,
        input logic [3:0]  opc,
        input logic [4:0]  prec,
        input logic [31:0] start,
        input logic [31:0] len,
        input logic [7:0]  uch
    );
        token_t t;
        t.kind  = kind;
        t.opc   = opc;
        t.prec  = prec;
        t.start = start;
        t.len   = len;
        t.uch   = uch;
        t.last  = 1'b0;
        return t;
    endfunction

    // pending operator resolved without an '=' partner
    function automatic token_t single_op(input logic [7:0] pend, input logic [31:0] start);
        token_t t;
        case (pend)
            CH_EQ:    t = make_tok(KIND_OPER, OPC_ASSIGN, PREC_ASSIGN, start, LEN_ONE, 8'h00);
            CH_GT:    t = make_tok(KIND_OPER, OPC_GT, PREC_MUL, start, LEN_ONE, 8'h00);
            CH_LT:    t = make_tok(KIND_OPER, OPC_LT, PREC_COMPARE, start, LEN_ONE, 8'h00);
            CH_SLASH: t = make_tok(KIND_OPER, OPC_DIV, PREC_MUL, start, LEN_ONE, 8'h00);
            default:  t = make_tok(KIND_UNKNOWN, OPC_ASSIGN, PREC_NONE, start, LEN_ONE, CH_BANG);
        endcase
        return t;
    endfunction

    // single-byte token formed by a byte that starts afresh
    function automatic token_t fresh_tok(input logic [7:0] c, input logic [31:0] start);
        token_t t;
        case (c)
            CH_LPAREN: t = make_tok(KIND_LPAREN, OPC_ASSIGN, PREC_NONE, start, LEN_ONE, 8'h00);
            CH_RPAREN: t = make_tok(KIND_RPAREN, OPC_ASSIGN, PREC_NONE, start, LEN_ONE, 8'h00);
            CH_LBRACK: t = make_tok(KIND_LBRACK, OPC_ASSIGN, PREC_NONE, start, LEN_ONE, 8'h00);
            CH_RBRACK: t = make_tok(KIND_RBRACK, OPC_ASSIGN, PREC_NONE, start, LEN_ONE, 8'h00);
            CH_LBRACE: t = make_tok(KIND_LBRACE, OPC_ASSIGN, PREC_NONE, start, LEN_ONE, 8'h00);
            CH_RBRACE: t = make_tok(KIND_RBRACE, OPC_ASSIGN, PREC_NONE, start, LEN_ONE, 8'h00);
            CH_COMMA:  t = make_tok(KIND_COMMA, OPC_ASSIGN, PREC_NONE, start, LEN_ONE, 8'h00);
            CH_PLUS:   t = make_tok(KIND_OPER, OPC_ADD, PREC_ADD, start, LEN_ONE, 8'h00);
            CH_MINUS:  t = make_tok(KIND_OPER, OPC_SUB, PREC_ADD, start, LEN_ONE, 8'h00);
            CH_STAR:   t = make_tok(KIND_OPER, OPC_MUL, PREC_MUL, start, LEN_ONE, 8'h00);
            CH_PCT:    t = make_tok(KIND_OPER, OPC_MOD, PREC_MUL, start, LEN_ONE, 8'h00);
            CH_DOT:    t = make_tok(KIND_OPER, OPC_DOT, PREC_DOT, start, LEN_ONE, 8'h00);
            default:   t = make_tok(KIND_UNKNOWN, OPC_ASSIGN, PREC_NONE, start, LEN_ONE, c);
        endcase
        return t;
    endfunction

    scan_mode_t               mode_reg, mode_next;
    logic [39:0]              prefix_reg, prefix_next;
    logic                     overflow_reg, overflow_next;
    logic [7:0]               pending_reg, pending_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [31:0]              len_reg, len_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;

    logic        accept;
    logic [7:0]  c;
    logic [31:0] pos32;
    logic [31:0] start32;
    logic [31:0] len_inc;
    logic        is_dig;
    logic        is_let;
    logic        is_spc;
    logic        is_opw;
    logic        fresh;
    logic        opw_pair;
    logic        opw_cmt;
    logic [4:0]  name_kind;
    logic [3:0]  pair_opc;
    logic        r_valid;
    token_t      r_tok;
    logic        f_valid;
    token_t      f_tok;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign c        = char_in;
    assign pos32    = 32'(pos_reg);
    assign start32  = 32'(start_reg);
    assign len_inc  = (len_reg == '1) ? len_reg : len_reg + LEN_ONE;

    always_comb
    begin
        is_dig   = c inside {[8'h30:8'h39]};
        is_let   = c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
        is_spc   = c inside {8'h20, [8'h09:8'h0D]};
        is_opw   = c inside {CH_EQ, CH_GT, CH_LT, CH_BANG, CH_SLASH};
        opw_cmt  = (pending_reg == CH_SLASH) && (c == CH_SLASH);
        opw_pair = (c == CH_EQ) && (pending_reg != CH_SLASH);
    end

    always_comb
    begin
        name_kind = KIND_NAME;
        if (!overflow_reg)
        begin
            if (len_reg == LEN_KW2 && prefix_reg == KW_DO)
                name_kind = KIND_DO;
            else if (len_reg == LEN_KW2 && prefix_reg == KW_IF)
                name_kind = KIND_IF;
            else if (len_reg == LEN_KW4 && prefix_reg == KW_ELSE)
                name_kind = KIND_ELSE;
            else if (len_reg == LEN_KW5 && prefix_reg == KW_WHILE)
                name_kind = KIND_WHILE;
            else if (len_reg == LEN_KW3 && prefix_reg == KW_END)
                name_kind = KIND_END;
        end
    end

    always_comb
    begin
        case (pending_reg)
            CH_EQ:   pair_opc = OPC_EQ;
            CH_GT:   pair_opc = OPC_GE;
            CH_LT:   pair_opc = OPC_LE;
            default: pair_opc = OPC_NE;
        endcase
    end

    // does the byte start afresh after the open token is dealt with
    always_comb
    begin
        if (op)
            fresh = 1'b0;
        else
        begin
            case (mode_reg)
                MODE_INT:  fresh = !is_dig;
                MODE_NAME: fresh = !is_let;
                MODE_STR:  fresh = 1'b0;
                MODE_CMT:  fresh = 1'b0;
                MODE_OPW:  fresh = !(opw_cmt || opw_pair);
                default:   fresh = 1'b1;
            endcase
        end
    end

    // token outputs: r closes the open token, f is the byte's own token or eof
    always_comb
    begin
        r_valid = 1'b0;
        r_tok   = make_tok(KIND_INT, OPC_ASSIGN, PREC_NONE, start32, len_reg, 8'h00);
        f_valid = 1'b0;
        f_tok   = fresh_tok(c, pos32);
        if (op)
        begin
            f_valid = 1'b1;
            f_tok   = make_tok(KIND_EOF, OPC_ASSIGN, PREC_NONE, pos32, LEN_NONE, 8'h00);
            case (mode_reg)
                MODE_INT:
                    r_valid = 1'b1;
                MODE_STR:
                begin
                    r_valid = 1'b1;
                    r_tok.kind = KIND_STRING;
                end
                MODE_NAME:
                begin
                    r_valid = 1'b1;
                    r_tok.kind = name_kind;
                end
                MODE_OPW:
                begin
                    r_valid = 1'b1;
                    r_tok   = single_op(pending_reg, start32);
                end
                default:
                    r_valid = 1'b0;
            endcase
        end
        else
        begin
            case (mode_reg)
                MODE_INT:
                    r_valid = !is_dig;
                MODE_NAME:
                begin
                    r_valid    = !is_let;
                    r_tok.kind = name_kind;
                end
                MODE_STR:
                begin
                    r_valid    = (c == CH_QUOTE);
                    r_tok.kind = KIND_STRING;
                end
                MODE_OPW:
                begin
                    r_valid = !opw_cmt;
                    if (opw_pair)
                        r_tok = make_tok(KIND_OPER, pair_opc, PREC_COMPARE, start32,
                                         LEN_TWO, 8'h00);
                    else
                        r_tok = single_op(pending_reg, start32);
                end
                default:
                    r_valid = 1'b0;
            endcase
            f_valid = fresh && !(is_spc || is_dig || is_let || is_opw || c == CH_QUOTE);
        end

        push_data.two  = r_valid && f_valid;
        push_data.tok0 = r_valid ? r_tok : f_tok;
        push_data.tok1 = f_tok;
        push_data.tok0.last = !(r_valid && f_valid);
        push_data.tok1.last = 1'b1;
        push = accept && (r_valid || f_valid);
    end

    // scanner state update
    always_comb
    begin
        mode_next     = mode_reg;
        prefix_next   = prefix_reg;
        overflow_next = overflow_reg;
        pending_next  = pending_reg;
        start_next    = start_reg;
        len_next      = len_reg;
        pos_next      = pos_reg + 1'b1;
        if (op)
        begin
            // end of input: back to the reset state for the next source
            mode_next     = MODE_IDLE;
            prefix_next   = '0;
            overflow_next = 1'b0;
            pending_next  = '0;
            start_next    = '0;
            len_next      = '0;
            pos_next      = '0;
        end
        else
        begin
            case (mode_reg)
                MODE_INT:
                begin
                    if (is_dig)
                        len_next = len_inc;
                    else
                        mode_next = MODE_IDLE;
                end
                MODE_NAME:
                begin
                    if (is_let)
                    begin
                        len_next      = len_inc;
                        prefix_next   = {prefix_reg[31:0], c};
                        overflow_next = overflow_reg || (len_inc > LEN_KW5);
                    end
                    else
                        mode_next = MODE_IDLE;
                end
                MODE_STR:
                begin
                    if (c == CH_QUOTE)
                        mode_next = MODE_IDLE;
                    else
                        len_next = len_inc;
                end
                MODE_CMT:
                begin
                    if (c == CH_LF)
                        mode_next = MODE_IDLE;
                end
                MODE_OPW:
                begin
                    pending_next = '0;
                    mode_next    = opw_cmt ? MODE_CMT : MODE_IDLE;
                end
                default:
                    mode_next = MODE_IDLE;
            endcase

            if (fresh && !is_spc)
            begin
                if (is_dig)
                begin
                    mode_next  = MODE_INT;
                    start_next = pos_reg;
                    len_next   = LEN_ONE;
                end
                else if (is_let)
                begin
                    mode_next     = MODE_NAME;
                    start_next    = pos_reg;
                    len_next      = LEN_ONE;
                    prefix_next   = {32'h0, c};
                    overflow_next = 1'b0;
                end
                else if (c == CH_QUOTE)
                begin
                    mode_next  = MODE_STR;
                    start_next = pos_reg;
                    len_next   = LEN_ONE;
                end
                else if (is_opw)
                begin
                    mode_next    = MODE_OPW;
                    start_next   = pos_reg;
                    len_next     = LEN_ONE;
                    pending_next = c;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            prefix_reg   <= '0;
            overflow_reg <= 1'b0;
            pending_reg  <= '0;
            start_reg    <= '0;
            len_reg      <= '0;
            pos_reg      <= '0;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            prefix_reg   <= prefix_next;
            overflow_reg <= overflow_next;
            pending_reg  <= pending_next;
            start_reg    <= start_next;
            len_reg      <= len_next;
            pos_reg      <= pos_next;
        end
    end

endmodule

/* src/sts_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_queue
// Short queue of token bundles between the scanner front and back ends.
// ----------------------------------------------------------------------------
module sts_queue
    import sts_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    output logic    full,
    input  logic    pop,
    output bundle_t head,
    output logic    empty
);

    bundle_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_BITS:0]   count_reg, count_next;

    assign full  = (count_reg == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* src/sts_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_back
// Scanner back end: splits queued bundles into single tokens and drives the
// registered output channel at one token per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module sts_back
    import sts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        queue_empty,
    input  bundle_t     head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  token_kind,
    output logic [3:0]  operator_code,
    output logic [4:0]  precedence,
    output logic [31:0] token_start,
    output logic [31:0] token_length,
    output logic [7:0]  unknown_char,
    output logic        last_of_run
);

    logic   sel_reg, sel_next;
    logic   valid_reg, valid_next;
    token_t tok_reg;
    logic   load;
    logic   take;
    token_t tok_sel;

    always_comb
    begin
        load       = !valid_reg || !out_stall;
        take       = load && !queue_empty;
        tok_sel    = sel_reg ? head.tok1 : head.tok0;
        // release the bundle once its final token is taken into the output register
        pop        = take && (sel_reg || !head.two);
        sel_next   = take ? !pop : sel_reg;
        valid_next = load ? !queue_empty : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg   <= sel_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            tok_reg <= tok_sel;
    end

    assign out_valid     = valid_reg;
    assign token_kind    = tok_reg.kind;
    assign operator_code = tok_reg.opc;
    assign precedence    = tok_reg.prec;
    assign token_start   = tok_reg.start;
    assign token_length  = tok_reg.len;
    assign unknown_char  = tok_reg.uch;
    assign last_of_run   = tok_reg.last;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the source token scanner.
// ----------------------------------------------------------------------------
// Feeds short source texts, each closed by an end-of-input beat: a directed
// set first, then random texts assembled from keywords, names, integers,
// strings, comments, operators, punctuation, whitespace and stray bytes.
// A tracker rebuilds the token stream from each accepted beat and compares
// every token that leaves the block against it, field by field. Both ports
// idle and stall at random, and the output is held off for a long stretch
// once so that the internal token queue fills and pushes back.
// ----------------------------------------------------------------------------
module tb_top
    import sts_pkg::*;
();

    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          RANDOM_BEATS  = 525;
    localparam int          LONG_HOLD     = 100;
    localparam int          DRAIN_CYCLES  = 20;
    localparam logic [3:0]  OPC_NONE      = 4'd0;
    localparam logic [7:0]  UCH_NONE      = 8'd0;

    typedef struct packed {
        logic       op;
        logic [7:0] ch;
    } beat_t;

    // ------------------------------------------------------------------------
    // Token tracker: own copy of the scanner state, expected token stream
    // ------------------------------------------------------------------------
    class token_tracker;
        token_t      expected_tokens[$];
        token_t      beat_tokens[$];
        int unsigned errors;
        scan_mode_t  mode;
        logic [39:0] tail_letters;
        logic        long_name;
        logic [7:0]  held_op;
        logic [31:0] run_start;
        logic [31:0] run_len;
        logic [31:0] offset;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            mode         = MODE_IDLE;
            tail_letters = '0;
            long_name    = 1'b0;
            held_op      = '0;
            run_start    = '0;
            run_len      = '0;
            offset       = '0;
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_space(logic [7:0] c);
            return c == " " || (c >= 8'd9 && c <= 8'd13);
        endfunction

        function void queue_token(logic [4:0] kind, logic [3:0] opc, logic [4:0] prec,
                                  logic [31:0] start, logic [31:0] len, logic [7:0] uch);
            token_t t;
            if (beat_tokens.size() < 2)
            begin
                t.kind  = kind;
                t.opc   = opc;
                t.prec  = prec;
                t.start = start;
                t.len   = len;
                t.uch   = uch;
                t.last  = 1'b0;
                beat_tokens.insert(beat_tokens.size(), t);
            end
        endfunction

        function void start_run(scan_mode_t m, logic [31:0] pos);
            mode      = m;
            run_start = pos;
            run_len   = 32'd1;
        endfunction

        function void extend_run();
            if (run_len != '1)
                run_len++;
        endfunction

        function void flush_name();
            logic [4:0] kind;
            kind = KIND_NAME;
            if (!long_name)
            begin
                if (run_len == 2 && tail_letters == "do")
                    kind = KIND_DO;
                else if (run_len == 2 && tail_letters == "if")
                    kind = KIND_IF;
                else if (run_len == 4 && tail_letters == "else")
                    kind = KIND_ELSE;
                else if (run_len == 5 && tail_letters == "while")
                    kind = KIND_WHILE;
                else if (run_len == 3 && tail_letters == "end")
                    kind = KIND_END;
            end
            queue_token(kind, OPC_NONE, PREC_NONE, run_start, run_len, UCH_NONE);
        endfunction

        // held operator byte with no '=' partner
        function void flush_held_op();
            case (held_op)
                "=":     queue_token(KIND_OPER, OPC_ASSIGN, PREC_ASSIGN, run_start, 1, UCH_NONE);
                ">":     queue_token(KIND_OPER, OPC_GT, PREC_MUL, run_start, 1, UCH_NONE);
                "<":     queue_token(KIND_OPER, OPC_LT, PREC_COMPARE, run_start, 1, UCH_NONE);
                "/":     queue_token(KIND_OPER, OPC_DIV, PREC_MUL, run_start, 1, UCH_NONE);
                default: queue_token(KIND_UNKNOWN, OPC_NONE, PREC_NONE, run_start, 1, "!");
            endcase
        endfunction

        function void flush_pair_op();
            logic [3:0] opc;
            case (held_op)
                "=":     opc = OPC_EQ;
                ">":     opc = OPC_GE;
                "<":     opc = OPC_LE;
                default: opc = OPC_NE;
            endcase
            queue_token(KIND_OPER, opc, PREC_COMPARE, run_start, 2, UCH_NONE);
        endfunction

        function void scan_fresh(logic [7:0] c, logic [31:0] pos);
            if (is_space(c))
                return;
            if (is_digit(c))
                start_run(MODE_INT, pos);
            else if (is_letter(c))
            begin
                start_run(MODE_NAME, pos);
                tail_letters = {32'd0, c};
                long_name    = 1'b0;
            end
            else
            begin
                case (c)
                    "\"":                    start_run(MODE_STR, pos);
                    "=", ">", "<", "!", "/":
                    begin
                        start_run(MODE_OPW, pos);
                        held_op = c;
                    end
                    "(": queue_token(KIND_LPAREN, OPC_NONE, PREC_NONE, pos, 1, UCH_NONE);
                    ")": queue_token(KIND_RPAREN, OPC_NONE, PREC_NONE, pos, 1, UCH_NONE);
                    "[": queue_token(KIND_LBRACK, OPC_NONE, PREC_NONE, pos, 1, UCH_NONE);
                    "]": queue_token(KIND_RBRACK, OPC_NONE, PREC_NONE, pos, 1, UCH_NONE);
                    "{": queue_token(KIND_LBRACE, OPC_NONE, PREC_NONE, pos, 1, UCH_NONE);
                    "}": queue_token(KIND_RBRACE, OPC_NONE, PREC_NONE, pos, 1, UCH_NONE);
                    ",": queue_token(KIND_COMMA, OPC_NONE, PREC_NONE, pos, 1, UCH_NONE);
                    "+": queue_token(KIND_OPER, OPC_ADD, PREC_ADD, pos, 1, UCH_NONE);
                    "-": queue_token(KIND_OPER, OPC_SUB, PREC_ADD, pos, 1, UCH_NONE);
                    "*": queue_token(KIND_OPER, OPC_MUL, PREC_MUL, pos, 1, UCH_NONE);
                    "%": queue_token(KIND_OPER, OPC_MOD, PREC_MUL, pos, 1, UCH_NONE);
                    ".": queue_token(KIND_OPER, OPC_DOT, PREC_DOT, pos, 1, UCH_NONE);
                    default: queue_token(KIND_UNKNOWN, OPC_NONE, PREC_NONE, pos, 1, c);
                endcase
            end
        endfunction

        // work out the tokens that one accepted input beat causes
        function void note_beat(logic op, logic [7:0] c);
            logic [31:0] pos;
            bit          fresh;
            beat_tokens.delete();
            pos   = offset;
            fresh = 1'b1;
            if (op)
            begin
                case (mode)
                    MODE_INT:  queue_token(KIND_INT, OPC_NONE, PREC_NONE, run_start, run_len,
                                           UCH_NONE);
                    MODE_STR:  queue_token(KIND_STRING, OPC_NONE, PREC_NONE, run_start, run_len,
                                           UCH_NONE);
                    MODE_NAME: flush_name();
                    MODE_OPW:  flush_held_op();
                    default:   ;
                endcase
                queue_token(KIND_EOF, OPC_NONE, PREC_NONE, pos, 0, UCH_NONE);
                clear_state();
            end
            else
            begin
                case (mode)
                    MODE_INT:
                    begin
                        if (is_digit(c))
                        begin
                            extend_run();
                            fresh = 1'b0;
                        end
                        else
                        begin
                            queue_token(KIND_INT, OPC_NONE, PREC_NONE, run_start, run_len,
                                        UCH_NONE);
                            mode = MODE_IDLE;
                        end
                    end
                    MODE_NAME:
                    begin
                        if (is_letter(c))
                        begin
                            extend_run();
                            tail_letters = {tail_letters[31:0], c};
                            if (run_len > 5)
                                long_name = 1'b1;
                            fresh = 1'b0;
                        end
                        else
                        begin
                            flush_name();
                            mode = MODE_IDLE;
                        end
                    end
                    MODE_STR:
                    begin
                        if (c == "\"")
                        begin
                            queue_token(KIND_STRING, OPC_NONE, PREC_NONE, run_start, run_len,
                                        UCH_NONE);
                            mode = MODE_IDLE;
                        end
                        else
                            extend_run();
                        fresh = 1'b0;
                    end
                    MODE_CMT:
                    begin
                        if (c == "\n")
                            mode = MODE_IDLE;
                        fresh = 1'b0;
                    end
                    MODE_OPW:
                    begin
                        if (held_op == "/" && c == "/")
                        begin
                            mode  = MODE_CMT;
                            fresh = 1'b0;
                        end
                        else if (c == "=" && held_op != "/")
                        begin
                            flush_pair_op();
                            mode  = MODE_IDLE;
                            fresh = 1'b0;
                        end
                        else
                        begin
                            flush_held_op();
                            mode = MODE_IDLE;
                        end
                        if (mode != MODE_OPW)
                            held_op = '0;
                    end
                    default: mode = MODE_IDLE;
                endcase
                if (fresh)
                    scan_fresh(c, pos);
                offset++;
            end
            if (beat_tokens.size() > 0)
                beat_tokens[beat_tokens.size() - 1].last = 1'b1;
            foreach (beat_tokens[i])
                expected_tokens.insert(expected_tokens.size(), beat_tokens[i]);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_token(token_t got);
            token_t want;
            if (expected_tokens.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected token, expected none, actual kind %0d start %0d",
                         $time, got.kind, got.start);
                return;
            end
            want = expected_tokens.pop_front();
            compare_field("token_kind", 32'(want.kind), 32'(got.kind));
            compare_field("operator_code", 32'(want.opc), 32'(got.opc));
            compare_field("precedence", 32'(want.prec), 32'(got.prec));
            compare_field("token_start", want.start, got.start);
            compare_field("token_length", want.len, got.len);
            compare_field("unknown_char", 32'(want.uch), 32'(got.uch));
            compare_field("last_of_run", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, block
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        op;
    logic [7:0]  char_in;
    logic        out_valid;
    logic        out_stall;
    logic [4:0]  token_kind;
    logic [3:0]  operator_code;
    logic [4:0]  precedence;
    logic [31:0] token_start;
    logic [31:0] token_length;
    logic [7:0]  unknown_char;
    logic        last_of_run;

    token_tracker tracker = new();
    beat_t        beat_queue[$];
    int           beats_queued;
    int           beats_accepted;
    int           cycle_count;
    int           tx_wait;
    int           tx_burst;
    int           rx_wait;
    int           rx_burst;
    int           hold_left;
    bit           hold_request;
    string        keywords[5] = '{"do", "if", "else", "while", "end"};
    string        operators[14] = '{"=", "==", ">", ">=", "<", "<=", "!=", "!",
                                    "+", "-", "*", "%", ".", "/"};
    string        punctuation = "()[]{},";

    initial clk = 1'b0;
    always #6 clk = ~clk;

    source_token_scanner u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .char_in       (char_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .token_kind    (token_kind),
        .operator_code (operator_code),
        .precedence    (precedence),
        .token_start   (token_start),
        .token_length  (token_length),
        .unknown_char  (unknown_char),
        .last_of_run   (last_of_run)
    );

    // random wait before the next beat, with occasional runs of no wait
    function automatic int draw_wait(ref int burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    // ------------------------------------------------------------------------
    // Input side: one beat per handshake, hold payload while stalled
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        beat_t nxt;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                tracker.note_beat(op, char_in);
                beats_accepted++;
                tx_wait = draw_wait(tx_burst);
            end
            if (!in_valid || !in_stall)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    in_valid <= 1'b0;
                end
                else if (beat_queue.size() != 0)
                begin
                    nxt = beat_queue.pop_front();
                    in_valid <= 1'b1;
                    op       <= nxt.op;
                    char_in  <= nxt.ch;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output side: check each token, then stall at random
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        token_t got;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got.kind  = token_kind;
                got.opc   = operator_code;
                got.prec  = precedence;
                got.start = token_start;
                got.len   = token_length;
                got.uch   = unknown_char;
                got.last  = last_of_run;
                tracker.check_token(got);
                rx_wait = draw_wait(rx_burst);
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic add_byte(logic [7:0] b);
        beat_queue.insert(beat_queue.size(), beat_t'{op: 1'b0, ch: b});
        beats_queued++;
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic add_eof();
        beat_queue.insert(beat_queue.size(),
                          beat_t'{op: 1'b1, ch: 8'($urandom_range(0, 255))});
        beats_queued++;
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? "a" : "A";
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_space();
        int k;
        k = $urandom_range(0, 5);
        return (k == 0) ? " " : 8'(8 + k);
    endfunction

    // one lexical piece of random source text
    task automatic add_piece();
        string      kw;
        int         n;
        logic [7:0] b;
        kw = keywords[$urandom_range(0, 4)];
        case ($urandom_range(0, 13))
            0: add_text(kw);
            1:
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        repeat ($urandom_range(1, 3)) add_byte(rand_letter());
                        add_text(kw);
                    end
                    1:
                    begin
                        add_text(kw);
                        add_byte(rand_letter());
                    end
                    2: add_text(kw.toupper());
                    default: add_text(kw.substr(0, kw.len() - 2));
                endcase
            end
            2: repeat ($urandom_range(1, 9)) add_byte(rand_letter());
            3, 4: repeat ($urandom_range(1, 6)) add_byte(8'("0" + $urandom_range(0, 9)));
            5:
            begin
                add_byte("\"");
                n = $urandom_range(0, 6);
                repeat (n)
                begin
                    do b = 8'($urandom_range(0, 255)); while (b == "\"");
                    add_byte(b);
                end
                if ($urandom_range(0, 7) != 0)
                    add_byte("\"");
            end
            6:
            begin
                add_text("//");
                n = $urandom_range(0, 6);
                repeat (n)
                begin
                    do b = 8'($urandom_range(0, 255)); while (b == "\n");
                    add_byte(b);
                end
                if ($urandom_range(0, 5) != 0)
                    add_byte("\n");
            end
            7, 8: add_text(operators[$urandom_range(0, 13)]);
            9: add_byte(punctuation[$urandom_range(0, 6)]);
            10: add_byte(rand_space());
            11: add_byte(8'($urandom_range(0, 255)));
            default: add_byte(8'($urandom_range(128, 255)));
        endcase
    endtask

    task automatic wait_drained();
        while (beats_accepted != beats_queued || tracker.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int n_sources;
        int n_pieces;
        in_valid  <= 1'b0;
        op        <= 1'b0;
        char_in   <= 8'd0;
        out_stall <= 1'b0;
        rst_n     <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // keyword cut by a digit, string, comment, lone bang, a lone '=' and a '>='
        // pair, top and bottom byte values
        add_text("while9\"s\"//c\n!x=>=");
        add_byte(8'hFF);
        add_byte(8'h00);
        add_eof();
        // string still open at end of input
        add_text("\"ab");
        add_eof();
        // operator still awaiting its lookahead at end of input
        add_text("<");
        add_eof();
        // empty source
        add_eof();
        wait_drained();

        n_sources = 0;
        while (beats_queued < RANDOM_BEATS + 28)
        begin
            n_sources++;
            // hold the output off while a long text keeps coming
            if (n_sources == 4)
            begin
                hold_request = 1'b1;
                n_pieces     = 25;
            end
            else
                n_pieces = $urandom_range(0, 14);
            repeat (n_pieces)
            begin
                add_piece();
                if ($urandom_range(0, 1))
                    add_byte(rand_space());
            end
            add_eof();
            if ($urandom_range(0, 3) == 0)
                wait_drained();
            else
                while (beat_queue.size() > 8) @(posedge clk);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sim.f */
src/sts_pkg.sv
src/sts_front.sv
src/sts_queue.sv
src/sts_back.sv
src/source_token_scanner.sv
test/tb_top.sv
